// ===== hdl/pidc_pkg.sv =====
package pidc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int BOUND_W       = 31;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 3;
    // headroom for sums of a few words before saturation or clamping
    localparam int WIDE_W        = 36;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_PERIOD      = 3'd3,
        CFG_INT_BOUND   = 3'd4,
        CFG_DRV_BOUND   = 3'd5,
        CFG_DEAD_ZONE   = 3'd6,
        CFG_MODE        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [WORD_W-1:0] measurement;
        logic signed [WORD_W-1:0] setpoint;
        logic                     run_enable;
    } t_pidc_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] drive;
        logic                     in_dead_zone;
    } t_pidc_out;

    // saturate a wide signed value to one signed word
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'({1'b0, {(WORD_W-1){1'b1}}});
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            return v[WORD_W-1:0];
        end
    endfunction

    // clamp a wide signed value to +-bound
    function automatic logic signed [WORD_W-1:0] clamp_mag(input logic signed [WIDE_W-1:0] v,
                                                          input logic [BOUND_W-1:0] b);
        logic signed [WIDE_W-1:0] wb;
        wb = WIDE_W'({1'b0, b});
        if (v > wb) begin
            return WORD_W'({1'b0, b});
        end else if (v < -wb) begin
            return -WORD_W'({1'b0, b});
        end else begin
            return v[WORD_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/pidc_mul.sv =====
module pidc_mul import pidc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic signed [WORD_W:0]    i_a,
    input  logic signed [WORD_W:0]    i_b,
    output logic signed [WORD_W-1:0]  o_res
);

    localparam int PROD_W = 2 * (WORD_W + 1);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] w_shift;
    logic                     w_fits;

    always_comb begin
        n_prod = i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // arithmetic shift rounds toward minus infinity; saturate what does not fit
    always_comb begin
        w_shift = r_prod >>> FRAC_BITS;
        w_fits  = (&w_shift[PROD_W-1:WORD_W-1]) || (~|w_shift[PROD_W-1:WORD_W-1]);
        if (w_fits) begin
            o_res = w_shift[WORD_W-1:0];
        end else if (w_shift[PROD_W-1]) begin
            o_res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            o_res = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

endmodule

// ===== hdl/pid_controller_step.sv =====
// Fixed-point PID controller, one sample per input beat. Each beat carries a
// measurement, a setpoint and a run flag; each produces exactly one result beat
// with the clamped drive and a dead-zone flag. Values are signed Q(32-F).F with
// F = FRAC_BITS (Q16.16 by default); every product is floored and saturated.
// All four products (P, error times sample period, I, D) go through a single
// registered multiplier under a small sequencer, so one item occupies the block
// for a fixed walk of states: a running sample passes through ERR, CHK, PROP,
// INT, IMUL, IRES, DRES, CLAMP and DONE, and the next beat is taken once the
// sequencer is back in IDLE; a sample inside the dead zone goes from CHK to DONE
// and a disabled sample (run flag low, which clears the integral, previous error
// and previous drive) goes straight to DONE. The input is not ready while an
// item is in flight, and a result that cannot be loaded because the previous one
// has not been taken holds the sequencer in DONE.
// Results sit in an output register, so a new sample can be accepted while the
// previous result waits to be taken. Write registers through the config port
// only while the block is idle; that port is always ready. Mode bit 0 selects
// accumulating output (previous drive plus the PID sum), bit 1 enables integral
// separation, which clears the integral when 10*|error| >= 3*integral bound.
module pid_controller_step import pidc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pidc_in              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_pidc_out             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data
);

    localparam int MODE_ACCUM = 0;
    localparam int MODE_SEP   = 1;

    // reset bounds: 1000.0 and 1.0 in the chosen format, saturated to the field
    localparam longint ONE_FX     = longint'(1) << FRAC_BITS;
    localparam longint BOUND_MAX  = (longint'(1) << BOUND_W) - 1;
    localparam longint IBOUND_FX  = 1000 * ONE_FX;
    localparam logic [BOUND_W-1:0] IBOUND_RST =
        (IBOUND_FX > BOUND_MAX) ? {BOUND_W{1'b1}} : BOUND_W'(IBOUND_FX);
    localparam logic [BOUND_W-1:0] DBOUND_RST = BOUND_W'(ONE_FX);
    localparam logic [MODE_W-1:0]  MODE_RST   = MODE_W'(2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_CHK,
        S_PROP,
        S_INT,
        S_IMUL,
        S_IRES,
        S_DRES,
        S_CLAMP,
        S_DONE
    } t_state;

    // sequencer and output stage
    t_state                   r_state,     n_state;
    logic                     r_out_vld,   n_out_vld;
    t_pidc_out                r_out,       n_out;
    t_pidc_out                r_res,       n_res;

    // sample work registers
    t_pidc_in                 r_in,        n_in;
    logic signed [WORD_W-1:0] r_err,       n_err;
    logic signed [WORD_W-1:0] r_diff,      n_diff;
    logic                     r_sep_clr,   n_sep_clr;
    logic signed [WIDE_W-1:0] r_acc,       n_acc;

    // controller state carried between samples
    logic signed [WORD_W-1:0] r_last_err,  n_last_err;
    logic signed [WORD_W-1:0] r_integ,     n_integ;
    logic signed [WORD_W-1:0] r_last_drv,  n_last_drv;

    // configuration registers
    logic signed [WORD_W-1:0] r_gain_p,    n_gain_p;
    logic signed [WORD_W-1:0] r_gain_i,    n_gain_i;
    logic signed [WORD_W-1:0] r_gain_d,    n_gain_d;
    logic [BOUND_W-1:0]       r_period,    n_period;
    logic [BOUND_W-1:0]       r_ibound,    n_ibound;
    logic [BOUND_W-1:0]       r_dbound,    n_dbound;
    logic [BOUND_W-1:0]       r_dzone,     n_dzone;
    logic [MODE_W-1:0]        r_mode,      n_mode;

    // shared multiplier
    logic signed [WORD_W:0]   w_mul_a;
    logic signed [WORD_W:0]   w_mul_b;
    logic signed [WORD_W-1:0] w_mul_res;

    // error magnitude and comparisons
    logic [WORD_W-1:0]        w_mag;
    logic [WIDE_W-1:0]        w_mag10;
    logic [WIDE_W-1:0]        w_bound3;
    logic                     w_in_dz;
    logic signed [WIDE_W-1:0] w_isum;

    pidc_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_res (w_mul_res)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // feed the multiplier from whichever product this state issues
    always_comb begin
        case (r_state)
            S_CHK: begin
                w_mul_a = (WORD_W+1)'(r_gain_p);
                w_mul_b = (WORD_W+1)'(r_err);
            end
            S_PROP: begin
                w_mul_a = (WORD_W+1)'(r_err);
                w_mul_b = (WORD_W+1)'({2'b00, r_period});
            end
            S_IMUL: begin
                w_mul_a = (WORD_W+1)'(r_gain_i);
                w_mul_b = (WORD_W+1)'(r_integ);
            end
            S_IRES: begin
                w_mul_a = (WORD_W+1)'(r_gain_d);
                w_mul_b = (WORD_W+1)'(r_diff);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // |error| with the most negative word mapping to 2^31 unsigned;
    // 0.3 of the integral bound is tested exactly as 10*|e| < 3*bound
    always_comb begin
        w_mag    = r_err[WORD_W-1] ? (~r_err + WORD_W'(1)) : r_err;
        w_in_dz  = (w_mag <= {1'b0, r_dzone});
        w_mag10  = {1'b0, w_mag, 3'b000} + {3'b000, w_mag, 1'b0};
        w_bound3 = {4'b0000, r_ibound, 1'b0} + {5'b00000, r_ibound};
        w_isum   = WIDE_W'(r_integ) + WIDE_W'(w_mul_res);
    end

    always_comb begin
        n_state    = r_state;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        n_res      = r_res;
        n_in       = r_in;
        n_err      = r_err;
        n_diff     = r_diff;
        n_sep_clr  = r_sep_clr;
        n_acc      = r_acc;
        n_last_err = r_last_err;
        n_integ    = r_integ;
        n_last_drv = r_last_drv;
        n_gain_p   = r_gain_p;
        n_gain_i   = r_gain_i;
        n_gain_d   = r_gain_d;
        n_period   = r_period;
        n_ibound   = r_ibound;
        n_dbound   = r_dbound;
        n_dzone    = r_dzone;
        n_mode     = r_mode;

        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:    n_gain_p = i_cfg_data;
                CFG_GAIN_I:    n_gain_i = i_cfg_data;
                CFG_GAIN_D:    n_gain_d = i_cfg_data;
                CFG_PERIOD:    n_period = i_cfg_data[BOUND_W-1:0];
                CFG_INT_BOUND: n_ibound = i_cfg_data[BOUND_W-1:0];
                CFG_DRV_BOUND: n_dbound = i_cfg_data[BOUND_W-1:0];
                CFG_DEAD_ZONE: n_dzone  = i_cfg_data[BOUND_W-1:0];
                CFG_MODE:      n_mode   = i_cfg_data[MODE_W-1:0];
                default:       n_mode   = r_mode;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in;
                    if (i_in.run_enable) begin
                        n_state = S_ERR;
                    end else begin
                        // disabled sample: drop all controller state
                        n_last_err = '0;
                        n_integ    = '0;
                        n_last_drv = '0;
                        n_res      = '{drive: '0, in_dead_zone: 1'b0};
                        n_state    = S_DONE;
                    end
                end
            end
            S_ERR: begin
                n_err   = sat_word(WIDE_W'(r_in.setpoint) - WIDE_W'(r_in.measurement));
                n_state = S_CHK;
            end
            S_CHK: begin
                // P product issued here
                n_diff    = sat_word(WIDE_W'(r_err) - WIDE_W'(r_last_err));
                n_sep_clr = r_mode[MODE_SEP] && !(w_mag10 < w_bound3);
                if (w_in_dz) begin
                    n_last_drv = '0;
                    n_res      = '{drive: '0, in_dead_zone: 1'b1};
                    n_state    = S_DONE;
                end else begin
                    n_state = S_PROP;
                end
            end
            S_PROP: begin
                n_acc   = WIDE_W'(w_mul_res);
                n_state = S_INT;
            end
            S_INT: begin
                n_integ = r_sep_clr ? '0 : clamp_mag(w_isum, r_ibound);
                n_state = S_IMUL;
            end
            S_IMUL: begin
                n_state = S_IRES;
            end
            S_IRES: begin
                n_acc      = r_acc + WIDE_W'(w_mul_res);
                n_last_err = r_err;
                n_state    = S_DRES;
            end
            S_DRES: begin
                n_acc = r_acc + WIDE_W'(w_mul_res)
                      + (r_mode[MODE_ACCUM] ? WIDE_W'(r_last_drv) : WIDE_W'(0));
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_last_drv = clamp_mag(r_acc, r_dbound);
                n_res      = '{drive: clamp_mag(r_acc, r_dbound), in_dead_zone: 1'b0};
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_last_err <= '0;
            r_integ    <= '0;
            r_last_drv <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_period   <= '0;
            r_ibound   <= IBOUND_RST;
            r_dbound   <= DBOUND_RST;
            r_dzone    <= '0;
            r_mode     <= MODE_RST;
        end else begin
            r_state    <= n_state;
            r_out_vld  <= n_out_vld;
            r_last_err <= n_last_err;
            r_integ    <= n_integ;
            r_last_drv <= n_last_drv;
            r_gain_p   <= n_gain_p;
            r_gain_i   <= n_gain_i;
            r_gain_d   <= n_gain_d;
            r_period   <= n_period;
            r_ibound   <= n_ibound;
            r_dbound   <= n_dbound;
            r_dzone    <= n_dzone;
            r_mode     <= n_mode;
            r_out      <= n_out;
            r_res      <= n_res;
            r_in       <= n_in;
            r_err      <= n_err;
            r_diff     <= n_diff;
            r_sep_clr  <= n_sep_clr;
            r_acc      <= n_acc;
        end
    end

endmodule

// ===== hdl/pidc_chk.sv =====
module pidc_chk import pidc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  t_pidc_in              i_in,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  t_pidc_out             o_out,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data
);

    // one sample in flight: an accepted beat closes the input at once
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after a beat was accepted");

    // a fresh result is loaded only as the sequencer finishes a sample
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (!$past(o_in_ready) && o_in_ready))
        else $error("result appeared without a sample being finished");

    // dead-zone results carry zero drive
    a_dead_zone_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.in_dead_zone) |-> (o_out.drive == '0))
        else $error("dead-zone result with non-zero drive");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result beat changed while stalled");

endmodule

bind pid_controller_step pidc_chk u_pidc_chk (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pidc_pkg::*;

    localparam int     FRAC         = FRAC_BITS_DEF;
    localparam int     LIMIT_CYCLES = 600_000;
    localparam longint W_MAX        = 64'sd2147483647;
    localparam longint W_MIN        = -64'sd2147483648;

    // ------------------------------------------------------------------
    // Clock, reset and the signals that the bench drives into the block
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_pidc_in    in_beat   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    t_cfg_idx    cfg_index = CFG_GAIN_P;
    logic [31:0] cfg_data  = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    t_pidc_out   o_out;
    logic        o_cfg_ready;

    always #5 clk = ~clk;

    pid_controller_step u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Queues and run bookkeeping
    // ------------------------------------------------------------------
    t_pidc_in  pending_samples[$];   // samples waiting for the driver
    t_pidc_out expected_drives[$];   // predicted result beats, oldest first

    bit no_idle     = 1'b0;          // set by the stimulus: no gaps on either side
    bit rx_hold_arm = 1'b0;          // set by the stimulus: ask for one long receiver stall

    int tx_gap      = 0;
    int rx_gap      = 0;
    int rx_hold_cnt = 0;
    bit rx_hold_done = 1'b0;

    int n_accepted  = 0;
    int n_disabled  = 0;
    int n_results   = 0;
    int n_dead      = 0;
    int n_cfg       = 0;
    int mismatches  = 0;

    // ------------------------------------------------------------------
    // Controller model: configuration and state kept by the bench
    // ------------------------------------------------------------------
    longint cf_gain_p    = 0;
    longint cf_gain_i    = 0;
    longint cf_gain_d    = 0;
    longint cf_period    = 0;
    longint cf_int_bound = 65536000;
    longint cf_drv_bound = 65536;
    longint cf_dead_zone = 0;
    logic [1:0] cf_mode  = 2'b10;

    logic signed [31:0] st_last_err   = '0;
    logic signed [31:0] st_integral   = '0;
    logic signed [31:0] st_last_drive = '0;

    function automatic logic signed [31:0] sat_w(input longint v);
        if (v > W_MAX) return 32'h7FFF_FFFF;
        if (v < W_MIN) return 32'h8000_0000;
        return 32'(v);
    endfunction

    // floor the fixed-point product (arithmetic shift rounds down), then saturate
    function automatic logic signed [31:0] fx_product(input longint a, input longint b);
        longint p;
        p = a * b;
        return sat_w(p >>> FRAC);
    endfunction

    function automatic logic signed [31:0] clamp_bound(input longint v, input longint b);
        if (v > b) return 32'(b);
        if (v < -b) return 32'(-b);
        return 32'(v);
    endfunction

    // Advance the model by one accepted sample and return the drive beat it must produce.
    function automatic t_pidc_out pid_predict(input t_pidc_in s);
        longint err;
        longint mag;
        longint integ;
        longint total;
        logic signed [31:0] p_t;
        logic signed [31:0] i_t;
        logic signed [31:0] d_t;
        logic signed [31:0] diff;
        t_pidc_out r;
        r = '0;
        if (!s.run_enable) begin
            // disabled: drop every piece of history
            st_last_err   = '0;
            st_integral   = '0;
            st_last_drive = '0;
            return r;
        end
        err = sat_w(longint'($signed(s.setpoint)) - longint'($signed(s.measurement)));
        mag = (err < 0) ? -err : err;
        if (mag <= cf_dead_zone) begin
            // inside the dead zone only the previous drive is cleared
            st_last_drive  = '0;
            r.in_dead_zone = 1'b1;
            return r;
        end
        p_t = fx_product(cf_gain_p, err);
        // separation clears the integral once 10*|e| reaches 3*bound
        if (!cf_mode[1] || (mag * 10 < cf_int_bound * 3)) begin
            integ       = longint'(st_integral) + longint'(fx_product(err, cf_period));
            st_integral = clamp_bound(integ, cf_int_bound);
        end else begin
            st_integral = '0;
        end
        i_t         = fx_product(cf_gain_i, st_integral);
        diff        = sat_w(err - longint'(st_last_err));
        st_last_err = 32'(err);
        d_t         = fx_product(cf_gain_d, diff);
        total = longint'(p_t) + longint'(i_t) + longint'(d_t);
        if (cf_mode[0]) begin
            total = total + longint'(st_last_drive);
        end
        st_last_drive = clamp_bound(total, cf_drv_bound);
        r.drive       = st_last_drive;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    // Bound-style register; bit 31 is random since the block must ignore it.
    function automatic logic [31:0] rand_bound(input logic [31:0] typical);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = 32'h7FFF_FFFF;
            2: v = $urandom();
            default: v = $urandom_range(0, typical);
        endcase
        v[31] = $urandom_range(0, 1);
        return v;
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void push_sample(input logic [31:0] meas, input logic [31:0] setp,
                                        input logic run);
        t_pidc_in s;
        s.measurement = meas;
        s.setpoint    = setp;
        s.run_enable  = run;
        pending_samples.push_back(s);
    endfunction

    // One write on the register port; mirror it into the model on the accepting edge.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            CFG_GAIN_P:    cf_gain_p    = longint'($signed(data));
            CFG_GAIN_I:    cf_gain_i    = longint'($signed(data));
            CFG_GAIN_D:    cf_gain_d    = longint'($signed(data));
            CFG_PERIOD:    cf_period    = longint'({1'b0, data[30:0]});
            CFG_INT_BOUND: cf_int_bound = longint'({1'b0, data[30:0]});
            CFG_DRV_BOUND: cf_drv_bound = longint'({1'b0, data[30:0]});
            CFG_DEAD_ZONE: cf_dead_zone = longint'({1'b0, data[30:0]});
            CFG_MODE:      cf_mode      = data[1:0];
            default: ;
        endcase
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    // Hold the stimulus until the driver is empty and every predicted beat has come.
    // Sampling on the falling edge keeps this clear of the driver's own updates.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_drives.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Input driver: present queued samples, predict each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_drives.push_back(pid_predict(in_beat));
                n_accepted++;
                if (!in_beat.run_enable) n_disabled++;
            end
            // only move on once the current beat has gone (valid must not drop early)
            if (!in_valid || o_in_ready) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    in_beat  <= pending_samples.pop_front();
                    in_valid <= 1'b1;
                    tx_gap   <= no_idle ? 0 : gap_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver stall: counted here so the sender keeps offering meanwhile
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_hold_cnt  <= 0;
            rx_hold_done <= 1'b0;
        end else if (rx_hold_cnt != 0) begin
            rx_hold_cnt <= rx_hold_cnt - 1;
        end else if (rx_hold_arm && !rx_hold_done) begin
            rx_hold_cnt  <= 400;
            rx_hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_monitor
        t_pidc_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                n_results++;
                if (o_out.in_dead_zone) n_dead++;
                if (expected_drives.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: drive %0d dead zone %0b",
                                 o_out.drive, o_out.in_dead_zone);
                    end
                end else begin
                    want = expected_drives.pop_front();
                    if (o_out.drive !== want.drive || o_out.in_dead_zone !== want.in_dead_zone)
                    begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"result %0d: drive exp %0d got %0d, ",
                                      "dead zone exp %0b got %0b"},
                                     n_results, want.drive, o_out.drive,
                                     want.in_dead_zone, o_out.in_dead_zone);
                        end
                    end
                end
            end
            if (rx_gap != 0) begin
                rx_gap    <= rx_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= (rx_hold_cnt == 0);
                if (o_out_valid && out_ready) rx_gap <= no_idle ? 0 : gap_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout: %0d samples taken, %0d beats still expected",
                 n_accepted, expected_drives.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int p;
        int k;
        int r;
        int scale;
        logic [31:0] phase_base;
        logic [31:0] err_w;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: zero gains, so any step outside the dead zone drives zero.
        push_sample(32'd0, 32'd0, 1'b1);        // zero error sits on a zero dead zone
        push_sample(32'd0, 32'd1, 1'b1);
        push_sample(32'd5, 32'd5, 1'b0);        // disabled
        wait_drained();

        // Moderate gains, separation on; bit 31 of the period write must be dropped.
        write_reg(CFG_GAIN_P,    32'h0001_0000);
        write_reg(CFG_GAIN_I,    32'h0000_8000);
        write_reg(CFG_GAIN_D,    32'h0000_4000);
        write_reg(CFG_PERIOD,    32'h8000_028F);
        write_reg(CFG_INT_BOUND, 32'h0064_0000);
        write_reg(CFG_DRV_BOUND, 32'h03E8_0000);
        write_reg(CFG_DEAD_ZONE, 32'h0000_8000);
        write_reg(CFG_MODE,      32'h0000_0002);
        push_sample(32'd0, 32'h0000_8000, 1'b1);      // error right on the dead zone edge
        push_sample(32'd0, 32'hFFFF_8000, 1'b1);      // same, negative
        push_sample(32'd0, 32'h0000_8001, 1'b1);      // just outside
        push_sample(32'd0, 32'd1966080, 1'b1);        // 10|e| equals 3*bound: integral cleared
        push_sample(32'd0, 32'd1966079, 1'b1);        // just below: integral kept
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1); // error saturates high, drive clamps
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1); // error saturates low
        push_sample(32'd0, 32'h8000_0000, 1'b1);      // most negative error
        push_sample(32'd12345, 32'hFFFF_D96C, 1'b0);  // disable mid-run
        push_sample(32'd100000, 32'd150000, 1'b1);
        push_sample(32'd150000, 32'd100000, 1'b1);
        wait_drained();

        // Extreme gains, widest bounds, accumulating mode without separation.
        write_reg(CFG_GAIN_P,    32'h8000_0000);
        write_reg(CFG_GAIN_I,    32'h7FFF_FFFF);
        write_reg(CFG_GAIN_D,    32'h8000_0000);
        write_reg(CFG_PERIOD,    32'hFFFF_FFFF);
        write_reg(CFG_INT_BOUND, 32'hFFFF_FFFF);
        write_reg(CFG_DRV_BOUND, 32'hFFFF_FFFF);
        write_reg(CFG_DEAD_ZONE, 32'h0000_0000);
        write_reg(CFG_MODE,      32'hFFFF_FFFD);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        push_sample(32'hFFFF_FFFF, 32'd0, 1'b1);
        push_sample(32'd0, 32'hFFFF_FFFF, 1'b1);
        push_sample(32'h7FFF_FFFF, 32'd0, 1'b1);
        push_sample(32'd0, 32'd0, 1'b1);
        wait_drained();

        // Zero clamps and the widest dead zone; only the most negative error escapes it.
        write_reg(CFG_INT_BOUND, 32'h0000_0000);
        write_reg(CFG_DRV_BOUND, 32'h0000_0000);
        write_reg(CFG_DEAD_ZONE, 32'h7FFF_FFFF);
        write_reg(CFG_MODE,      32'h0000_0003);
        push_sample(32'd0, 32'h8000_0000, 1'b1);
        push_sample(32'd0, 32'h7FFF_FFFF, 1'b1);
        push_sample(32'hFFFF_FFFB, 32'd7, 1'b1);
        wait_drained();

        // Random phases: fresh settings each time, then mostly well-formed control
        // samples around a set point, with some noise and extremes mixed in.
        for (p = 0; p < 10; p++) begin
            wait_drained();
            no_idle = (p == 2 || p == 3 || p == 7);
            // phase 3 stalls the receiver for a long stretch while samples keep coming
            if (p == 3) rx_hold_arm = 1'b1;
            repeat (3) @(posedge clk);
            write_reg(CFG_GAIN_P,    rand_gain());
            write_reg(CFG_GAIN_I,    rand_gain());
            write_reg(CFG_GAIN_D,    rand_gain());
            write_reg(CFG_PERIOD,    rand_bound(32'h0002_0000));
            write_reg(CFG_INT_BOUND, rand_bound(32'h0200_0000));
            write_reg(CFG_DRV_BOUND, rand_bound(32'h0100_0000));
            write_reg(CFG_DEAD_ZONE, rand_bound(32'h0000_4000));
            write_reg(CFG_MODE,      {30'($urandom_range(0, 32'h3FFF_FFFF)),
                                      2'($urandom_range(0, 3))});
            phase_base = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            for (k = 0; k < 70; k++) begin
                // phase 5: sender pauses half way until every result is back
                if (p == 5 && k == 35) wait_drained();
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    push_sample($urandom(), $urandom(), 1'b0);
                end else if (r < 9) begin
                    push_sample($urandom(), $urandom(), 1'b1);
                end else if (r < 13) begin
                    push_sample(extreme_word(), extreme_word(), 1'b1);
                end else begin
                    scale = $urandom_range(0, 26);
                    err_w = $urandom_range(0, 1 << scale);
                    if ($urandom_range(0, 1)) err_w = -err_w;
                    push_sample(phase_base - err_w, phase_base, 1'b1);
                end
            end
        end

        wait_drained();
        // let any stray beat surface before the verdict
        repeat (20) @(posedge clk);

        $display("ran %0d samples (%0d disabled) across %0d register writes", n_accepted,
                 n_disabled, n_cfg);
        $display("checked %0d drive beats, %0d of them in the dead zone, %0d mismatches",
                 n_results, n_dead, mismatches);
        if (mismatches == 0 && expected_drives.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
